[src/crls_pkg.sv]
// ============================================================================
// crls_pkg: shared types and constants for the cross-limiting ratio selector
// Widths of the flow datapath, register defaults, mode and register codes,
// sequencer types and the divider request and response bundles.
// ============================================================================
package crls_pkg;

    // Flow and register widths
    localparam int FLOW_BITS   = 24;
    localparam int REG_W       = 16;
    // Q8.8 ratio times 64 lines up with a Q2.14 margin
    localparam int FRAC_SHIFT  = 6;
    localparam int MUL_A_W     = FLOW_BITS + REG_W;
    localparam int PROD_W      = MUL_A_W + REG_W;
    localparam int NUM_W       = MUL_A_W + FRAC_SHIFT;
    localparam int DEN_W       = REG_W + FRAC_SHIFT;
    // Quotient width: holds every fuel-side limit, rounded down to even for radix 4
    localparam int QUO_W       = ((FLOW_BITS + 11) / 2) * 2;
    localparam int QUO_HI_W    = NUM_W - QUO_W;
    localparam int DIV_ITER    = QUO_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_ITER);
    // Outer air limit is (Qf*S*E) >> 22
    localparam int OUTER_SHIFT = 22;
    localparam int MARG_W      = QUO_W + 1;
    localparam int CFG_IDX_W   = 3;

    // Register defaults, also used when a register holds zero
    localparam logic [REG_W-1:0] DEF_AFR         = REG_W'(4403);
    localparam logic [REG_W-1:0] DEF_AIR_MARGIN  = REG_W'(17203);
    localparam logic [REG_W-1:0] DEF_FUEL_MARGIN = REG_W'(15565);
    localparam logic [REG_W-1:0] DEF_EXTRA       = REG_W'(17203);

    // Margin clamp at +-(2^FLOW_BITS - 1)
    localparam logic signed [MARG_W-1:0] MARG_HI = $signed(MARG_W'({FLOW_BITS{1'b1}}));
    localparam logic signed [MARG_W-1:0] MARG_LO = -MARG_HI;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AFR_STOICH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_MARGIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FUEL_MARGIN = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA       = CFG_IDX_W'(4);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_AIR_LEADS,
        MODE_FUEL_LEADS,
        MODE_DOUBLE
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL2,
        ST_PROD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SEL,
        ST_MARGIN
    } state_t;

    // Limit being computed, in sequencer order
    typedef enum logic [2:0] {
        STEP_AIR_MIN,
        STEP_AIR_MAX,
        STEP_OUTER_AIR,
        STEP_FUEL_MAX,
        STEP_FUEL_MIN,
        STEP_OUTER_FUEL
    } step_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // Zero in a ratio or margin register means its default
    function automatic logic [REG_W-1:0] reg_or_default(
        input logic [REG_W-1:0] v,
        input logic [REG_W-1:0] dflt
    );
        return (v == '0) ? dflt : v;
    endfunction

    // Saturate a limit-width value to the flow width
    function automatic logic [FLOW_BITS-1:0] sat_flow(input logic [QUO_W-1:0] v);
        return (v[QUO_W-1:FLOW_BITS] != '0) ? {FLOW_BITS{1'b1}} : v[FLOW_BITS-1:0];
    endfunction

endpackage

[src/crls_mul.sv]
// ============================================================================
// crls_mul: shared registered multiplier
// One flow-by-register product per cycle, held while the enable is low.
// ============================================================================
module crls_mul
    import crls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [MUL_A_W-1:0] a,
    input  logic [REG_W-1:0]   b,
    output logic [PROD_W-1:0]  p
);

    logic [PROD_W-1:0] p_reg;
    logic [PROD_W-1:0] p_next;

    // Product or hold
    always_comb
    begin
        p_next = p_reg;
        if (en)
        begin
            p_next = PROD_W'(a) * PROD_W'(b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[src/crls_div.sv]
// ============================================================================
// crls_div: shared iterative divider
// Restoring division, two quotient bits per cycle; a quotient that would
// not fit the limit width is detected up front and returned all ones.
// ============================================================================
module crls_div
    import crls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     den_next;

    logic [DEN_W-1:0]     hi_ext;
    logic                 ovf;
    logic [DEN_W:0]       step1;
    logic [DEN_W:0]       step2;

    // One restoring step: returns {remainder, quotient bit}
    function automatic logic [DEN_W:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic             bit_in,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, den};
        if (t >= d)
        begin
            t = t - d;
            return {t[DEN_W-1:0], 1'b1};
        end
        return {t[DEN_W-1:0], 1'b0};
    endfunction

    // Overflow check on the high dividend part
    assign hi_ext = DEN_W'(req.dividend[NUM_W-1:QUO_W]);
    assign ovf    = (hi_ext >= req.divisor);

    // Two chained steps per cycle
    assign step1 = div_step(rem_reg, quo_reg[QUO_W-1], den_reg);
    assign step2 = div_step(step1[DEN_W:1], quo_reg[QUO_W-2], den_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            den_next = req.divisor;
            cnt_next = '0;
            if (ovf)
            begin
                quo_next  = '1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = hi_ext;
                quo_next  = req.dividend[QUO_W-1:0];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = step2[DEN_W:1];
            quo_next = {quo_reg[QUO_W-3:0], step1[0], step2[0]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[src/cross_limiting_ratio_selector_unit.sv]
// ============================================================================
// cross_limiting_ratio_selector_unit: air/fuel cross-limiting selector
// Sequence: five divisions on the shared radix-4 divider, the outer air product
//   from two passes of the shared multiplier, then selection and margins; a
//   division that saturates finishes early.
// Input: one item at a time, the input stalls until the sequencer is idle; the
//   next item is taken while a result still waits in the output register.
// Reset: registers return to their defaults, override flags clear, no output.
// ============================================================================
module cross_limiting_ratio_selector_unit
    import crls_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FLOW_BITS-1:0]       air_demand,
    input  logic [FLOW_BITS-1:0]       fuel_demand,
    input  logic [FLOW_BITS-1:0]       air_meas,
    input  logic [FLOW_BITS-1:0]       fuel_meas,
    // Output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [FLOW_BITS-1:0]       sp_air,
    output logic [FLOW_BITS-1:0]       sp_fuel,
    output logic                       air_override,
    output logic                       fuel_override,
    output logic signed [FLOW_BITS:0]  air_headroom,
    output logic signed [FLOW_BITS:0]  fuel_headroom,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [REG_W-1:0]           cfg_data
);

    // Configuration registers
    mode_t             mode_reg;
    logic [REG_W-1:0]  afr_reg;
    logic [REG_W-1:0]  ra_reg;
    logic [REG_W-1:0]  rf_reg;
    logic [REG_W-1:0]  extra_reg;

    // Sequencer
    state_t            state_reg;
    state_t            state_next;
    step_t             step_reg;
    step_t             step_next;

    // Latched item
    logic [FLOW_BITS-1:0] da_reg;
    logic [FLOW_BITS-1:0] df_reg;
    logic [FLOW_BITS-1:0] qa_reg;
    logic [FLOW_BITS-1:0] qf_reg;

    // Limits
    logic [QUO_W-1:0]  air_min_reg;
    logic [QUO_W-1:0]  air_max_reg;
    logic [QUO_W-1:0]  outer_air_reg;
    logic [QUO_W-1:0]  fuel_max_reg;
    logic [QUO_W-1:0]  fuel_min_reg;
    logic [QUO_W-1:0]  outer_fuel_reg;

    // Kept flags and selected setpoints
    logic              air_flag_reg;
    logic              air_flag_next;
    logic              fuel_flag_reg;
    logic              fuel_flag_next;
    logic [FLOW_BITS-1:0] spa_reg;
    logic [FLOW_BITS-1:0] spf_reg;

    // Output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [FLOW_BITS-1:0]      sp_air_reg;
    logic [FLOW_BITS-1:0]      sp_fuel_reg;
    logic                      air_ovr_reg;
    logic                      fuel_ovr_reg;
    logic signed [FLOW_BITS:0] air_hr_reg;
    logic signed [FLOW_BITS:0] fuel_hr_reg;

    // Decoded controls
    logic              in_take;
    logic              mul_en;
    logic              lim_wr;
    logic              sel_wr;
    logic              out_load;

    logic [REG_W-1:0]  s_eff;
    logic [REG_W-1:0]  ra_eff;
    logic [REG_W-1:0]  rf_eff;
    logic [REG_W-1:0]  e_eff;
    logic              has_qa;
    logic              has_qf;

    logic [MUL_A_W-1:0] mul_a;
    logic [REG_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [QUO_W-1:0]   lim_val;

    logic [QUO_W-1:0]   da_x;
    logic [QUO_W-1:0]   df_x;
    logic [QUO_W-1:0]   spa_q;
    logic [QUO_W-1:0]   spf_q;
    logic [QUO_W-1:0]   a_inner;
    logic [QUO_W-1:0]   f_inner;

    logic signed [MARG_W-1:0] ma_full;
    logic signed [MARG_W-1:0] mf_full;
    logic signed [MARG_W-1:0] ma_clip;
    logic signed [MARG_W-1:0] mf_clip;

    // Effective ratio and margins
    assign s_eff  = reg_or_default(afr_reg, DEF_AFR);
    assign ra_eff = reg_or_default(ra_reg, DEF_AIR_MARGIN);
    assign rf_eff = reg_or_default(rf_reg, DEF_FUEL_MARGIN);
    assign e_eff  = reg_or_default(extra_reg, DEF_EXTRA);
    assign has_qa = (qa_reg != '0);
    assign has_qf = (qf_reg != '0);

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            afr_reg   <= DEF_AFR;
            ra_reg    <= DEF_AIR_MARGIN;
            rf_reg    <= DEF_FUEL_MARGIN;
            extra_reg <= DEF_EXTRA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:        mode_reg  <= mode_t'(cfg_data[1:0]);
                CFG_AFR_STOICH:  afr_reg   <= cfg_data;
                CFG_AIR_MARGIN:  ra_reg    <= cfg_data;
                CFG_FUEL_MARGIN: rf_reg    <= cfg_data;
                CFG_EXTRA:       extra_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Shared multiplier operands
    always_comb
    begin
        mul_a = MUL_A_W'(qf_reg);
        mul_b = s_eff;
        if (state_reg == ST_MUL2)
        begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = e_eff;
        end
        else
        begin
            unique case (step_reg) inside
                STEP_AIR_MIN, STEP_AIR_MAX, STEP_OUTER_AIR:
                begin
                    mul_a = MUL_A_W'(qf_reg);
                    mul_b = s_eff;
                end
                STEP_FUEL_MAX:
                begin
                    mul_a = MUL_A_W'(qa_reg);
                    mul_b = ra_eff;
                end
                STEP_FUEL_MIN:
                begin
                    mul_a = MUL_A_W'(qa_reg);
                    mul_b = rf_eff;
                end
                STEP_OUTER_FUEL:
                begin
                    mul_a = MUL_A_W'(qa_reg);
                    mul_b = e_eff;
                end
                default:
                begin
                    mul_a = MUL_A_W'(qf_reg);
                    mul_b = s_eff;
                end
            endcase
        end
    end

    crls_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p)
    );

    // Divider request: air side divides Qf*S*64 by a margin, fuel side by 64*S
    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_GO);
        unique case (step_reg)
            STEP_AIR_MIN:
            begin
                div_req.dividend = {mul_p[MUL_A_W-1:0], {FRAC_SHIFT{1'b0}}};
                div_req.divisor  = DEN_W'(ra_eff);
            end
            STEP_AIR_MAX:
            begin
                div_req.dividend = {mul_p[MUL_A_W-1:0], {FRAC_SHIFT{1'b0}}};
                div_req.divisor  = DEN_W'(rf_eff);
            end
            default:
            begin
                div_req.dividend = NUM_W'(mul_p[MUL_A_W-1:0]);
                div_req.divisor  = {s_eff, {FRAC_SHIFT{1'b0}}};
            end
        endcase
    end

    crls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: next state and controls
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mul_en     = 1'b0;
        lim_wr     = 1'b0;
        sel_wr     = 1'b0;
        out_load   = 1'b0;
        lim_val    = div_rsp.quotient;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_AIR_MIN;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mul_en = 1'b1;
                state_next = (step_reg == STEP_OUTER_AIR) ? ST_MUL2 : ST_DIV_GO;
            end
            ST_MUL2:
            begin
                mul_en     = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                lim_val    = QUO_W'(mul_p[PROD_W-1:OUTER_SHIFT]);
                lim_wr     = 1'b1;
                step_next  = STEP_FUEL_MAX;
                state_next = ST_MUL;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    lim_wr = 1'b1;
                    unique case (step_reg)
                        STEP_AIR_MIN:    step_next = STEP_AIR_MAX;
                        STEP_AIR_MAX:    step_next = STEP_OUTER_AIR;
                        STEP_OUTER_AIR:  step_next = STEP_FUEL_MAX;
                        STEP_FUEL_MAX:   step_next = STEP_FUEL_MIN;
                        STEP_FUEL_MIN:   step_next = STEP_OUTER_FUEL;
                        default:         step_next = STEP_AIR_MIN;
                    endcase
                    state_next = (step_reg == STEP_OUTER_FUEL) ? ST_SEL : ST_MUL;
                end
            end
            ST_SEL:
            begin
                sel_wr     = 1'b1;
                state_next = ST_MARGIN;
            end
            ST_MARGIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_AIR_MIN;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            da_reg <= air_demand;
            df_reg <= fuel_demand;
            qa_reg <= air_meas;
            qf_reg <= fuel_meas;
        end
    end

    // Limit capture
    always_ff @(posedge clk)
    begin
        if (lim_wr)
        begin
            unique case (step_reg)
                STEP_AIR_MIN:    air_min_reg    <= lim_val;
                STEP_AIR_MAX:    air_max_reg    <= lim_val;
                STEP_OUTER_AIR:  outer_air_reg  <= lim_val;
                STEP_FUEL_MAX:   fuel_max_reg   <= lim_val;
                STEP_FUEL_MIN:   fuel_min_reg   <= lim_val;
                STEP_OUTER_FUEL: outer_fuel_reg <= lim_val;
                default:         ;
            endcase
        end
    end

    // Selectors per mode; absent limits are masked by the flow-present terms, the air minimum by being zero
    always_comb
    begin
        da_x           = QUO_W'(da_reg);
        df_x           = QUO_W'(df_reg);
        spa_q          = da_x;
        spf_q          = df_x;
        a_inner        = da_x;
        f_inner        = df_x;
        air_flag_next  = air_flag_reg;
        fuel_flag_next = fuel_flag_reg;
        unique case (mode_reg)
            MODE_AIR_LEADS:
            begin
                air_flag_next = (air_min_reg > da_x);
                if (air_flag_next)
                begin
                    spa_q = air_min_reg;
                end
                fuel_flag_next = has_qa && (fuel_max_reg < df_x);
                if (fuel_flag_next)
                begin
                    spf_q = fuel_max_reg;
                end
            end
            MODE_FUEL_LEADS:
            begin
                if (has_qa && (fuel_min_reg > df_x))
                begin
                    spf_q = fuel_min_reg;
                end
                if (has_qf && (air_max_reg < da_x))
                begin
                    spa_q = air_max_reg;
                end
            end
            MODE_DOUBLE:
            begin
                if (has_qf && (outer_air_reg < da_x))
                begin
                    a_inner = outer_air_reg;
                end
                air_flag_next = (air_min_reg > a_inner);
                spa_q = air_flag_next ? air_min_reg : a_inner;
                if (has_qa && (fuel_min_reg > df_x))
                begin
                    f_inner = fuel_min_reg;
                end
                fuel_flag_next = has_qa && (outer_fuel_reg < f_inner);
                spf_q = fuel_flag_next ? outer_fuel_reg : f_inner;
            end
            default:
            begin
                spa_q = da_x;
                spf_q = df_x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_flag_reg  <= 1'b0;
            fuel_flag_reg <= 1'b0;
        end
        else if (sel_wr)
        begin
            air_flag_reg  <= air_flag_next;
            fuel_flag_reg <= fuel_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_wr)
        begin
            spa_reg <= sat_flow(spa_q);
            spf_reg <= sat_flow(spf_q);
        end
    end

    // Safety margins against the air-leads limits, clamped
    always_comb
    begin
        ma_full = $signed({1'b0, QUO_W'(spa_reg)});
        if (has_qf)
        begin
            ma_full = $signed({1'b0, QUO_W'(spa_reg)}) - $signed({1'b0, air_min_reg});
        end
        mf_full = '0;
        if (has_qa)
        begin
            mf_full = $signed({1'b0, fuel_max_reg}) - $signed({1'b0, QUO_W'(spf_reg)});
        end
        ma_clip = ma_full;
        if (ma_full > MARG_HI)
        begin
            ma_clip = MARG_HI;
        end
        else if (ma_full < MARG_LO)
        begin
            ma_clip = MARG_LO;
        end
        mf_clip = mf_full;
        if (mf_full > MARG_HI)
        begin
            mf_clip = MARG_HI;
        end
        else if (mf_full < MARG_LO)
        begin
            mf_clip = MARG_LO;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sp_air_reg   <= spa_reg;
            sp_fuel_reg  <= spf_reg;
            air_ovr_reg  <= air_flag_reg;
            fuel_ovr_reg <= fuel_flag_reg;
            air_hr_reg   <= ma_clip[FLOW_BITS:0];
            fuel_hr_reg  <= mf_clip[FLOW_BITS:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign sp_air        = sp_air_reg;
    assign sp_fuel       = sp_fuel_reg;
    assign air_override  = air_ovr_reg;
    assign fuel_override = fuel_ovr_reg;
    assign air_headroom  = air_hr_reg;
    assign fuel_headroom = fuel_hr_reg;

endmodule

[dv/tb_cross_limiting_ratio_selector_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_cross_limiting_ratio_selector_unit: self-checking bench for the selector
// Drives air/fuel demand and flow items through the valid/stall input channel,
// predicts every setpoint, override flag and safety margin with its own
// fixed-point model of the selectors, and compares each output transfer
// field by field. The bench covers all modes and register corners, including
// zero registers and writes to unused indexes, with random idling on both
// sides.
// ============================================================================
module tb_cross_limiting_ratio_selector_unit;
    import crls_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam longint      TIMEOUT_NS    = 10_000_000;
    localparam int          RANDOM_ITEMS  = 1280;
    localparam int          TAIL_ITEMS    = 100;
    localparam int          SETTLE_CYCLES = 150;
    localparam int          RATIO_FRAC    = 8;
    localparam logic [63:0] FLOW_LIMIT    = (64'd1 << FLOW_BITS) - 64'd1;
    localparam longint      MARGIN_CAP    = longint'(FLOW_LIMIT);
    localparam logic [FLOW_BITS-1:0] FLOW_ALL_ONES = '1;

    typedef struct packed {
        logic [FLOW_BITS-1:0] air_demand;
        logic [FLOW_BITS-1:0] fuel_demand;
        logic [FLOW_BITS-1:0] air_meas;
        logic [FLOW_BITS-1:0] fuel_meas;
    } flow_item_t;

    typedef struct packed {
        logic [FLOW_BITS-1:0]      sp_air;
        logic [FLOW_BITS-1:0]      sp_fuel;
        logic                      air_override;
        logic                      fuel_override;
        logic signed [FLOW_BITS:0] air_headroom;
        logic signed [FLOW_BITS:0] fuel_headroom;
    } setpoint_set_t;

    // DUT-facing signals
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FLOW_BITS-1:0]      air_demand = '0;
    logic [FLOW_BITS-1:0]      fuel_demand = '0;
    logic [FLOW_BITS-1:0]      air_meas = '0;
    logic [FLOW_BITS-1:0]      fuel_meas = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [FLOW_BITS-1:0]      sp_air;
    logic [FLOW_BITS-1:0]      sp_fuel;
    logic                      air_override;
    logic                      fuel_override;
    logic signed [FLOW_BITS:0] air_headroom;
    logic signed [FLOW_BITS:0] fuel_headroom;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [REG_W-1:0]          cfg_data = '0;

    // Shadow copy of the registers and the kept override flags
    mode_t            mode_reg = MODE_NONE;
    logic [REG_W-1:0] stoich_reg = DEF_AFR;
    logic [REG_W-1:0] air_margin_reg = DEF_AIR_MARGIN;
    logic [REG_W-1:0] fuel_margin_reg = DEF_FUEL_MARGIN;
    logic [REG_W-1:0] extra_reg = DEF_EXTRA;
    logic             air_flag_q = 1'b0;
    logic             fuel_flag_q = 1'b0;

    setpoint_set_t pending_setpoints[$];
    int            error_count = 0;
    bit            idle_en = 1'b1;
    int            stall_left = 0;

    cross_limiting_ratio_selector_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .air_demand    (air_demand),
        .fuel_demand   (fuel_demand),
        .air_meas      (air_meas),
        .fuel_meas     (fuel_meas),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sp_air        (sp_air),
        .sp_fuel       (sp_fuel),
        .air_override  (air_override),
        .fuel_override (fuel_override),
        .air_headroom  (air_headroom),
        .fuel_headroom (fuel_headroom),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Selector prediction; updates the kept flags like the block does
    function automatic setpoint_set_t predict_setpoints(input flow_item_t f);
        logic [63:0]   s;
        logic [63:0]   ra;
        logic [63:0]   rf;
        logic [63:0]   ex;
        logic [63:0]   qa;
        logic [63:0]   qf;
        logic [63:0]   spa;
        logic [63:0]   spf;
        logic [63:0]   air_min;
        logic [63:0]   fuel_max;
        logic [63:0]   lim;
        logic          has_qa;
        logic          has_qf;
        longint        ma;
        longint        mf;
        setpoint_set_t r;
        // zero in a register falls back to its default
        s  = (stoich_reg == '0)      ? 64'(DEF_AFR)         : 64'(stoich_reg);
        ra = (air_margin_reg == '0)  ? 64'(DEF_AIR_MARGIN)  : 64'(air_margin_reg);
        rf = (fuel_margin_reg == '0) ? 64'(DEF_FUEL_MARGIN) : 64'(fuel_margin_reg);
        ex = (extra_reg == '0)       ? 64'(DEF_EXTRA)       : 64'(extra_reg);
        qa = 64'(f.air_meas);
        qf = 64'(f.fuel_meas);
        has_qa = (qa != 64'd0);
        has_qf = (qf != 64'd0);
        air_min  = has_qf ? ((qf * s) << FRAC_SHIFT) / ra : 64'd0;
        fuel_max = has_qa ? (qa * ra) / (s << FRAC_SHIFT) : 64'd0;
        spa = 64'(f.air_demand);
        spf = 64'(f.fuel_demand);
        case (mode_reg)
            MODE_AIR_LEADS:
            begin
                air_flag_q = (air_min > spa);
                if (air_flag_q)
                    spa = air_min;
                fuel_flag_q = has_qa && (fuel_max < spf);
                if (fuel_flag_q)
                    spf = fuel_max;
            end
            MODE_FUEL_LEADS:
            begin
                if (has_qa)
                begin
                    lim = (qa * rf) / (s << FRAC_SHIFT);
                    if (lim > spf)
                        spf = lim;
                end
                if (has_qf)
                begin
                    lim = ((qf * s) << FRAC_SHIFT) / rf;
                    if (lim < spa)
                        spa = lim;
                end
            end
            MODE_DOUBLE:
            begin
                // air: clamp to outer limit, then air minimum wins last
                if (has_qf)
                begin
                    lim = (qf * s * ex) >> OUTER_SHIFT;
                    if (lim < spa)
                        spa = lim;
                end
                air_flag_q = (air_min > spa);
                if (air_flag_q)
                    spa = air_min;
                // fuel: raise to fuel minimum, then outer limit wins last
                if (has_qa)
                begin
                    lim = (qa * rf) / (s << FRAC_SHIFT);
                    if (lim > spf)
                        spf = lim;
                end
                lim = has_qa ? (qa * ex) / (s << FRAC_SHIFT) : 64'd0;
                fuel_flag_q = has_qa && (lim < spf);
                if (fuel_flag_q)
                    spf = lim;
            end
            default: ;
        endcase
        if (spa > FLOW_LIMIT)
            spa = FLOW_LIMIT;
        if (spf > FLOW_LIMIT)
            spf = FLOW_LIMIT;
        ma = has_qf ? longint'(spa) - longint'(air_min) : longint'(spa);
        mf = has_qa ? longint'(fuel_max) - longint'(spf) : 64'sd0;
        if (ma > MARGIN_CAP)
            ma = MARGIN_CAP;
        if (ma < -MARGIN_CAP)
            ma = -MARGIN_CAP;
        if (mf > MARGIN_CAP)
            mf = MARGIN_CAP;
        if (mf < -MARGIN_CAP)
            mf = -MARGIN_CAP;
        r.sp_air        = spa[FLOW_BITS-1:0];
        r.sp_fuel       = spf[FLOW_BITS-1:0];
        r.air_override  = air_flag_q;
        r.fuel_override = fuel_flag_q;
        r.air_headroom  = ma[FLOW_BITS:0];
        r.fuel_headroom = mf[FLOW_BITS:0];
        return r;
    endfunction

    function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [REG_W-1:0] data);
        case (idx)
            CFG_MODE:        mode_reg = mode_t'(data[1:0]);
            CFG_AFR_STOICH:  stoich_reg = data;
            CFG_AIR_MARGIN:  air_margin_reg = data;
            CFG_FUEL_MARGIN: fuel_margin_reg = data;
            CFG_EXTRA:       extra_reg = data;
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [63:0] expv,
                                          input logic signed [63:0] gotv);
        if (expv !== gotv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, gotv);
            error_count++;
        end
    endfunction

    // Flow with a wide spread of magnitudes, zero and full scale included
    function automatic logic [FLOW_BITS-1:0] pick_flow();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FLOW_ALL_ONES;
            2:       return FLOW_BITS'($urandom);
            default: return FLOW_BITS'($urandom) >> $urandom_range(0, FLOW_BITS - 1);
        endcase
    endfunction

    // Demand up to about 25 percent away from a limit, so selectors flip
    function automatic logic [FLOW_BITS-1:0] near_value(input logic [63:0] target);
        logic [63:0] delta;
        logic [63:0] v;
        delta = (target >> $urandom_range(2, 12)) + 64'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
            v = target + delta;
        else
            v = (target > delta) ? target - delta : 64'd0;
        return (v > FLOW_LIMIT) ? FLOW_ALL_ONES : v[FLOW_BITS-1:0];
    endfunction

    function automatic logic [REG_W-1:0] pick_reg(input logic [REG_W-1:0] dflt);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return REG_W'(1);
            2:       return '1;
            3:       return REG_W'($urandom);
            default: return dflt + REG_W'($urandom_range(0, 4095)) - REG_W'(2048);
        endcase
    endfunction

    // One input transfer; valid stays high for back-to-back items
    task automatic send_flow(input logic [FLOW_BITS-1:0] da, input logic [FLOW_BITS-1:0] df,
                             input logic [FLOW_BITS-1:0] qa, input logic [FLOW_BITS-1:0] qf);
        flow_item_t f;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        f.air_demand  = da;
        f.fuel_demand = df;
        f.air_meas    = qa;
        f.fuel_meas   = qf;
        in_valid    <= 1'b1;
        air_demand  <= da;
        fuel_demand <= df;
        air_meas    <= qa;
        fuel_meas   <= qf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_setpoints.push_back(predict_setpoints(f));
    endtask

    task automatic send_random_item();
        logic [63:0]          s;
        logic [63:0]          qa;
        logic [63:0]          qf;
        logic [FLOW_BITS-1:0] da;
        logic [FLOW_BITS-1:0] df;
        s  = (stoich_reg == '0) ? 64'(DEF_AFR) : 64'(stoich_reg);
        qa = 64'(pick_flow());
        qf = 64'(pick_flow());
        if ($urandom_range(0, 3) == 0)
        begin
            da = FLOW_BITS'($urandom);
            df = FLOW_BITS'($urandom);
        end
        else
        begin
            // demands around the stoichiometric partner of each flow
            da = near_value((qf * s) >> RATIO_FRAC);
            df = near_value((qa << RATIO_FRAC) / s);
        end
        send_flow(da, df, qa[FLOW_BITS-1:0], qf[FLOW_BITS-1:0]);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data,
                             input bit close_burst);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        note_reg_write(idx, data);
        if (close_burst)
            cfg_valid <= 1'b0;
    endtask

    // Call only with the block idle
    task automatic program_settings(input logic [REG_W-1:0] mode_data,
                                    input logic [REG_W-1:0] s, input logic [REG_W-1:0] ra,
                                    input logic [REG_W-1:0] rf, input logic [REG_W-1:0] ex);
        write_reg(CFG_MODE, mode_data, 1'b0);
        write_reg(CFG_AFR_STOICH, s, 1'b0);
        write_reg(CFG_AIR_MARGIN, ra, 1'b0);
        write_reg(CFG_FUEL_MARGIN, rf, 1'b0);
        write_reg(CFG_EXTRA, ex, 1'b1);
    endtask

    // Reset mode: setpoints follow demands, flags stay clear
    task automatic test_pass_through();
        send_flow('0, '0, '0, '0);
        send_flow(FLOW_ALL_ONES, FLOW_ALL_ONES, FLOW_ALL_ONES, FLOW_ALL_ONES);
        send_flow(FLOW_ALL_ONES, '0, '0, FLOW_ALL_ONES);
        send_flow('0, FLOW_ALL_ONES, FLOW_ALL_ONES, '0);
    endtask

    task automatic test_air_leads();
        drain_results();
        program_settings(REG_W'(MODE_AIR_LEADS), DEF_AFR, DEF_AIR_MARGIN,
                         DEF_FUEL_MARGIN, DEF_EXTRA);
        send_flow(100, 5000, 1000, 1000);
        send_flow(FLOW_ALL_ONES, 10, 1000, 1000);
        send_flow('0, FLOW_ALL_ONES, '0, '0);
        // air minimum past full scale: setpoint saturates
        send_flow(5, 5, FLOW_ALL_ONES, FLOW_ALL_ONES);
    endtask

    // Flags from the air-leads run must survive untouched
    task automatic test_fuel_leads();
        drain_results();
        program_settings(REG_W'(MODE_FUEL_LEADS), DEF_AFR, DEF_AIR_MARGIN,
                         DEF_FUEL_MARGIN, DEF_EXTRA);
        send_flow(FLOW_ALL_ONES, '0, 100000, 1000);
        send_flow('0, FLOW_ALL_ONES, 100000, 1000);
        send_flow(FLOW_ALL_ONES, '0, '0, '0);
    endtask

    task automatic test_double_cross();
        drain_results();
        program_settings(REG_W'(MODE_DOUBLE), DEF_AFR, DEF_AIR_MARGIN,
                         DEF_FUEL_MARGIN, DEF_EXTRA);
        send_flow(FLOW_ALL_ONES, '0, 1000000, 10000);
        send_flow('0, FLOW_ALL_ONES, 1000000, 10000);
        send_flow(170000, 58000, 1000000, 10000);
        send_flow(FLOW_ALL_ONES, FLOW_ALL_ONES, '0, '0);
    endtask

    // Register extremes, zero registers, masked mode and unused indexes
    task automatic test_register_corners();
        drain_results();
        program_settings(REG_W'(MODE_DOUBLE), REG_W'(1), '1, REG_W'(1), '1);
        send_flow(FLOW_ALL_ONES, FLOW_ALL_ONES, FLOW_ALL_ONES, FLOW_ALL_ONES);
        send_flow(1, 1, 1, 1);
        drain_results();
        program_settings(REG_W'(MODE_AIR_LEADS), '1, REG_W'(1), '1, REG_W'(1));
        send_flow(FLOW_ALL_ONES, FLOW_ALL_ONES, FLOW_ALL_ONES, FLOW_ALL_ONES);
        send_flow(1, 1, 1, 1);
        drain_results();
        for (int i = int'(CFG_EXTRA) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), REG_W'($urandom), 1'b0);
        program_settings({{(REG_W - 2){1'b1}}, MODE_FUEL_LEADS}, '0, '0, '0, '0);
        send_flow(FLOW_ALL_ONES, '0, 12345, 678);
        send_flow('0, FLOW_ALL_ONES, 12345, 678);
    endtask

    // Random settings per phase; each phase starts from an idle block
    task automatic test_random_phases();
        int sent;
        int phase;
        int count;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            idle_en = (phase % 4 != 3);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_EXTRA) + 1, (1 << CFG_IDX_W) - 1)),
                          REG_W'($urandom), 1'b0);
            program_settings(REG_W'($urandom), pick_reg(DEF_AFR), pick_reg(DEF_AIR_MARGIN),
                             pick_reg(DEF_FUEL_MARGIN), pick_reg(DEF_EXTRA));
            count = $urandom_range(40, 120);
            repeat (count)
                send_random_item();
            sent += count;
            phase++;
        end
    endtask

    // Closing stretch at full rate, no idling on either side
    task automatic test_quiet_tail();
        drain_results();
        idle_en = 1'b0;
        program_settings(REG_W'(MODE_DOUBLE), DEF_AFR, DEF_AIR_MARGIN,
                         DEF_FUEL_MARGIN, DEF_EXTRA);
        repeat (TAIL_ITEMS)
            send_random_item();
    endtask

    // Result checking and receiver stall bursts
    always @(posedge clk)
    begin : result_check
        setpoint_set_t exp_set;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_setpoints.size() == 0)
            begin
                $error("result transfer with nothing pending: sp_air %0d, sp_fuel %0d",
                       sp_air, sp_fuel);
                error_count++;
            end
            else
            begin
                exp_set = pending_setpoints.pop_front();
                compare_field("sp_air", exp_set.sp_air, sp_air);
                compare_field("sp_fuel", exp_set.sp_fuel, sp_fuel);
                compare_field("air_override", exp_set.air_override, air_override);
                compare_field("fuel_override", exp_set.fuel_override, fuel_override);
                compare_field("air_headroom", exp_set.air_headroom, air_headroom);
                compare_field("fuel_headroom", exp_set.fuel_headroom, fuel_headroom);
            end
        end
        if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 16);
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pass_through();
        test_air_leads();
        test_fuel_leads();
        test_double_cross();
        test_register_corners();
        test_random_phases();
        test_quiet_tail();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/crls_pkg.sv
src/crls_mul.sv
src/crls_div.sv
src/cross_limiting_ratio_selector_unit.sv
dv/tb_cross_limiting_ratio_selector_unit.sv
